### hdl/sawbc_pkg.sv
// Shared types and constants of the set-associative write-back cache tag core.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sawbc_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 5;
    localparam int SET_BITS    = 6;
    localparam int TAG_BITS    = 21;
    localparam int WAY_BITS    = 2;
    localparam int ADDR_BITS   = 32;
    localparam int CNT_BITS    = 32;
    localparam int PEN_BITS    = 10;
    localparam int ACC_BITS    = 11;
    localparam int OUT_BITS    = 168;

    localparam logic [PEN_BITS-1:0] PEN_RESET = PEN_BITS'(100);

    typedef logic [SET_BITS-1:0] t_set;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [WAY_BITS-1:0] t_way;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef struct packed {
        logic valid;
        logic dirty;
        t_tag tag;
        t_cnt last_use;
        t_cnt last_op;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    typedef struct packed {
        logic                hit;
        logic                dirty_ev;
        t_way                way;
        t_line               old_line;
        logic [ACC_BITS-1:0] acc;
        t_cnt                new_cycle;
        t_row                new_row;
    } t_lookup;

endpackage

`default_nettype wire

### hdl/sawbc_line_mem.sv
// Line memory of the cache tag core: one row of all ways per set, registered read data.
// Per-set valid flops make unwritten rows read as zero after reset. Uses sawbc_pkg.
`default_nettype none

module sawbc_line_mem (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rd_en,
    input  sawbc_pkg::t_set      i_rd_set,
    input  wire                  i_wr_en,
    input  sawbc_pkg::t_set      i_wr_set,
    input  sawbc_pkg::t_row      i_wr_row,
    output sawbc_pkg::t_row      o_rd_row
);
    import sawbc_pkg::*;

    t_row             r_mem [SETS];
    logic [SETS-1:0]  r_row_vld;
    t_row             r_rd_row;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_set];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_row : '0;

endmodule

`default_nettype wire

### hdl/sawbc_lookup.sv
// Hit detection, victim selection and line update for one set row.
// Combinational; uses sawbc_pkg for the row and result types.
`default_nettype none

module sawbc_lookup (
    input  sawbc_pkg::t_row                     i_row,
    input  sawbc_pkg::t_tag                     i_tag,
    input  wire                                 i_wr,
    input  wire [sawbc_pkg::PEN_BITS-1:0]       i_pen,
    input  sawbc_pkg::t_cnt                     i_cycle,
    input  sawbc_pkg::t_cnt                     i_op,
    output sawbc_pkg::t_lookup                  o_res
);
    import sawbc_pkg::*;

    logic                hit;
    logic                found_inv;
    t_way                hit_way;
    t_way                inv_way;
    t_way                lru_way;
    t_way                way;
    t_line               old_line;
    logic                dirty_ev;
    logic [ACC_BITS-1:0] pen_x;
    logic [ACC_BITS-1:0] acc;
    t_cnt                incr;
    t_cnt                new_cycle;
    t_line               new_line;
    t_row                new_row;

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        found_inv = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w].valid && i_row[w].tag == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!i_row[w].valid) begin
                found_inv = 1'b1;
                inv_way   = WAY_BITS'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (i_row[lru_way].last_use > i_row[w].last_use) begin
                lru_way = WAY_BITS'(w);
            end
        end

        way      = hit ? hit_way : (found_inv ? inv_way : lru_way);
        old_line = i_row[way];
        dirty_ev = !hit && old_line.dirty;
        pen_x    = ACC_BITS'(i_pen);
        acc      = ACC_BITS'(1) + (hit ? '0 : pen_x) + (dirty_ev ? pen_x : '0);
        if (hit) begin
            incr = CNT_BITS'(1);
        end else if (i_wr && dirty_ev) begin
            incr = CNT_BITS'(acc);
        end else begin
            incr = CNT_BITS'(i_pen) + CNT_BITS'(1);
        end
        new_cycle = i_cycle + incr;

        new_line          = old_line;
        if (hit) begin
            new_line.dirty = old_line.dirty | i_wr;
        end else begin
            new_line.valid = 1'b1;
            new_line.dirty = i_wr;
            new_line.tag   = i_tag;
        end
        new_line.last_use = new_cycle;
        new_line.last_op  = i_op;
        new_row           = i_row;
        new_row[way]      = new_line;

        o_res.hit       = hit;
        o_res.dirty_ev  = dirty_ev;
        o_res.way       = way;
        o_res.old_line  = old_line;
        o_res.acc       = acc;
        o_res.new_cycle = new_cycle;
        o_res.new_row   = new_row;
    end

endmodule

`default_nettype wire

### hdl/set_assoc_writeback_cache_tags_core.sv
// Top level of the set-associative write-back cache tag core with LRU replacement.
// Instantiates sawbc_line_mem and sawbc_lookup; uses sawbc_pkg.
//
// For each input transaction the set's row of all four ways is read from the line
// memory when the input is accepted, then compared, updated and written back in the
// lookup state, when the result loads the output register. The line memory is read
// and written once per access; a stalled output holds the lookup state.
// Miss penalty writes are taken at any time and must only occur while idle.
`default_nettype none

module set_assoc_writeback_cache_tags_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire [sawbc_pkg::ADDR_BITS-1:0]      i_s_tdata,  // address
    input  wire                                 i_s_tuser,  // is_write
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // hit, dirty_eviction, set_index, tag, way, old_tag, old_valid, old_dirty,
    // old_op_index, op_index, access_cycles, cycle_count, zero fill
    output logic [sawbc_pkg::OUT_BITS-1:0]      o_m_tdata,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [sawbc_pkg::PEN_BITS-1:0]       i_cfg_data   // miss_penalty
);
    import sawbc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                r_state;
    logic                n_state;
    t_set                r_set;
    t_tag                r_tag;
    logic                r_wr;
    t_cnt                r_cycle;
    t_cnt                r_ops;
    logic [PEN_BITS-1:0] r_pen;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    logic    in_acc;
    logic    done;
    t_set    in_set;
    t_row    rd_row;
    t_lookup res;
    t_tag    old_tag;

    assign in_set     = i_s_tdata[OFFSET_BITS +: SET_BITS];
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign done       = (r_state == ST_LOOK) && (!r_out_valid || i_m_tready);
    assign o_cfg_ready = 1'b1;

    sawbc_line_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_acc),
        .i_rd_set (in_set),
        .i_wr_en  (done),
        .i_wr_set (r_set),
        .i_wr_row (res.new_row),
        .o_rd_row (rd_row)
    );

    sawbc_lookup u_lookup (
        .i_row   (rd_row),
        .i_tag   (r_tag),
        .i_wr    (r_wr),
        .i_pen   (r_pen),
        .i_cycle (r_cycle),
        .i_op    (r_ops),
        .o_res   (res)
    );

    assign old_tag = res.old_line.valid ? res.old_line.tag : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cycle     <= '0;
            r_ops       <= '0;
            r_pen       <= PEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_pen <= i_cfg_data;
            end
            if (done) begin
                r_cycle     <= res.new_cycle;
                r_ops       <= r_ops + CNT_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set <= in_set;
            r_tag <= i_s_tdata[OFFSET_BITS + SET_BITS +: TAG_BITS];
            r_wr  <= i_s_tuser;
        end
        if (done) begin
            r_out_data <= {7'b0, res.new_cycle, res.acc, r_ops, res.old_line.last_op,
                           res.old_line.dirty, res.old_line.valid, old_tag, res.way,
                           r_tag, r_set, res.dirty_ev, res.hit};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire
